// ===== src/grouped_decimal_formatter_assert.svh =====
// Assertion macros for the grouped decimal formatter.
// Included by the top level; depends on nothing else.
`ifndef GROUPED_DECIMAL_FORMATTER_ASSERT_SVH
`define GROUPED_DECIMAL_FORMATTER_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define GDF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define GDF_ASSERT_NEXT(lbl, clk, rst_n, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gdf_pkg.sv =====
// Shared types, constants and helpers of the grouped decimal formatter.
// Used by every module of the block; depends on nothing.
package gdf_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned CountW    = 4;
  localparam int unsigned CharW     = 8;
  localparam int unsigned LangW     = 3;

  localparam logic [ValueW-1:0] RecipTen = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift     = 35;

  localparam logic [CharW-1:0] CharZero   = 8'h30;
  localparam logic [CharW-1:0] CharNine   = 8'h39;
  localparam logic [CharW-1:0] SepEnglish = 8'h2C;
  localparam logic [CharW-1:0] SepOther   = 8'h2E;

  localparam logic [LangW-1:0] LangEnglish = 3'd0;
  localparam logic RegLanguage = 1'b0;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIGIT,
    B_SEP
  } back_state_e;

  typedef struct packed {
    logic [MaxDigits-1:0][DigitW-1:0] digits;
    logic [CountW-1:0]                count;
  } dec_item_t;

  function automatic logic [1:0] mod3(input logic [CountW-1:0] x);
    logic [1:0] r;
    case (x)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
      default:                              r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

// ===== src/gdf_front.sv =====
// Front end: accepts a value and splits it into decimal digits, one a cycle.
// Depends on gdf_pkg; feeds the digit queue.
module gdf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gdf_pkg::ValueW-1:0]    value_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output gdf_pkg::dec_item_t            push_item_o
);

  gdf_pkg::front_state_e state_q, state_d;

  logic [gdf_pkg::ValueW-1:0]                          v_q, v_d;
  logic [gdf_pkg::MaxDigits-1:0][gdf_pkg::DigitW-1:0]  dig_q, dig_d;
  logic [gdf_pkg::CountW-1:0]                          cnt_q, cnt_d;

  logic [2*gdf_pkg::ValueW-1:0] prod;
  logic [gdf_pkg::ValueW-1:0]   quot;
  logic [gdf_pkg::ValueW-1:0]   quot_x10;
  logic [gdf_pkg::ValueW-1:0]   rem_full;
  logic [gdf_pkg::DigitW-1:0]   digit;
  logic                         accept;

  assign prod     = v_q * gdf_pkg::RecipTen;
  assign quot     = {{gdf_pkg::RecipShift - gdf_pkg::ValueW{1'b0}},
                     prod[2*gdf_pkg::ValueW-1:gdf_pkg::RecipShift]};
  assign quot_x10 = {quot[gdf_pkg::ValueW-4:0], 3'b000} + {quot[gdf_pkg::ValueW-2:0], 1'b0};
  assign rem_full = v_q - quot_x10;
  assign digit    = rem_full[gdf_pkg::DigitW-1:0];
  assign accept   = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      gdf_pkg::F_IDLE: begin
        if (in_valid_i) state_d = gdf_pkg::F_CONV;
      end
      gdf_pkg::F_CONV: begin
        if (quot == '0) state_d = gdf_pkg::F_PUSH;
      end
      gdf_pkg::F_PUSH: begin
        if (push_ready_i) state_d = gdf_pkg::F_IDLE;
      end
      default: state_d = gdf_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != gdf_pkg::F_IDLE);
    push_valid_o = (state_q == gdf_pkg::F_PUSH);
    push_item_o.digits = dig_q;
    push_item_o.count  = cnt_q;
    v_d   = v_q;
    dig_d = dig_q;
    cnt_d = cnt_q;
    if (accept) begin
      v_d   = value_i;
      cnt_d = '0;
    end else if (state_q == gdf_pkg::F_CONV) begin
      v_d   = quot;
      dig_d = {dig_q[gdf_pkg::MaxDigits-2:0], digit};
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdf_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    dig_q <= dig_d;
    cnt_q <= cnt_d;
  end

endmodule

// ===== src/gdf_fifo.sv =====
// Short queue of converted digit sets between front and back end.
// Depends on gdf_pkg for the entry type.
module gdf_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  gdf_pkg::dec_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_i,
  output gdf_pkg::dec_item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  gdf_pkg::dec_item_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_item_i;
  end

endmodule

// ===== src/gdf_back.sv =====
// Back end: emits the queued digits most significant first, with separators.
// Depends on gdf_pkg; drives the registered output channel.
module gdf_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gdf_pkg::LangW-1:0]   language_i,
  input  logic                        pop_valid_i,
  output logic                        pop_o,
  input  gdf_pkg::dec_item_t          pop_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [gdf_pkg::CharW-1:0]   character_o,
  output logic                        last_o
);

  gdf_pkg::back_state_e state_q, state_d;

  logic [gdf_pkg::MaxDigits-1:0][gdf_pkg::DigitW-1:0] dig_q, dig_d, src_digits;
  logic [gdf_pkg::CountW-1:0] sig_q, sig_d, src_sig;
  logic [1:0]                 phase_q, phase_d, src_phase;
  logic                       out_valid_q, out_valid_d;
  logic [gdf_pkg::CharW-1:0]  char_q, char_d;
  logic                       last_q, last_d;
  logic                       load, emit_digit, emit_sep;
  logic [gdf_pkg::CharW-1:0]  sep;

  assign sep  = (language_i == gdf_pkg::LangEnglish) ? gdf_pkg::SepEnglish
                                                     : gdf_pkg::SepOther;
  assign load = !out_valid_q || !out_stall_i;

  always_comb begin
    if (state_q == gdf_pkg::B_IDLE) begin
      src_digits = pop_item_i.digits;
      src_sig    = pop_item_i.count - 1'b1;
      src_phase  = gdf_pkg::mod3(src_sig);
    end else begin
      src_digits = dig_q;
      src_sig    = sig_q;
      src_phase  = phase_q;
    end
    emit_digit = load && (((state_q == gdf_pkg::B_IDLE) && pop_valid_i) ||
                          (state_q == gdf_pkg::B_DIGIT));
    emit_sep   = load && (state_q == gdf_pkg::B_SEP);
  end

  always_comb begin
    state_d = state_q;
    if (emit_digit) begin
      if (src_sig == '0) begin
        state_d = gdf_pkg::B_IDLE;
      end else if (src_phase == 2'd0) begin
        state_d = gdf_pkg::B_SEP;
      end else begin
        state_d = gdf_pkg::B_DIGIT;
      end
    end else if (emit_sep) begin
      state_d = gdf_pkg::B_DIGIT;
    end
  end

  always_comb begin
    pop_o       = load && (state_q == gdf_pkg::B_IDLE) && pop_valid_i;
    dig_d       = dig_q;
    sig_d       = sig_q;
    phase_d     = phase_q;
    out_valid_d = load ? (emit_digit || emit_sep) : out_valid_q;
    char_d      = char_q;
    last_d      = last_q;
    if (emit_digit) begin
      dig_d   = {{gdf_pkg::DigitW{1'b0}}, src_digits[gdf_pkg::MaxDigits-1:1]};
      sig_d   = src_sig - 1'b1;
      phase_d = (src_phase == 2'd0) ? 2'd2 : src_phase - 1'b1;
      char_d  = gdf_pkg::CharZero + {{gdf_pkg::CharW-gdf_pkg::DigitW{1'b0}}, src_digits[0]};
      last_d  = (src_sig == '0);
    end else if (emit_sep) begin
      char_d = sep;
      last_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gdf_pkg::B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q   <= dig_d;
    sig_q   <= sig_d;
    phase_q <= phase_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

endmodule

// ===== src/grouped_decimal_formatter.sv =====
// Grouped decimal formatter: unsigned 32-bit value in, ASCII decimal text out
// with thousands separators, one character per output item, last flag on the end.
// Input channel: in_valid_i / in_stall_o with value_i; accepted when valid and
// not stalled. Output channel: out_valid_o / out_stall_i with character_o and
// last_o. Config: APB-style port, one register (language) at address 0.
// A value's digits come from the divide-by-ten unit (one 32x32 reciprocal
// multiply per digit); the digit set then enters the queue, and the back end
// registers its first character on the output. The back end sends one
// character a cycle while text is queued and the receiver does not stall,
// n + (n - 1) / 3 per value of n digits, up to 13. Sustained throughput is
// set by the slower of the front end, which takes a new value only after
// the last digit set has entered the queue, and the back end. The queue
// lets the front convert a value while the back emits the previous text.
// Reset clears the language register to English, empties the queue and drops
// output valid. While the receiver stalls, the output item holds, the back end
// waits, and once the queue fills the front end stalls the input.
// Depends on gdf_pkg, gdf_front, gdf_fifo, gdf_back and the assertion macros.
`include "grouped_decimal_formatter_assert.svh"

module grouped_decimal_formatter #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [gdf_pkg::ValueW-1:0]  value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [gdf_pkg::CharW-1:0]   character_o,
  output logic                        last_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [gdf_pkg::LangW-1:0] language_q, language_d;
  logic                      cfg_write;

  logic               push_valid, push_ready, pop_valid, pop;
  gdf_pkg::dec_item_t push_item, pop_item;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    language_d = language_q;
    if (cfg_write && (paddr[2] == gdf_pkg::RegLanguage)) begin
      language_d = pwdata[gdf_pkg::LangW-1:0];
    end
    prdata = '0;
    if (paddr[2] == gdf_pkg::RegLanguage) begin
      prdata = {{32-gdf_pkg::LangW{1'b0}}, language_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      language_q <= gdf_pkg::LangEnglish;
    end else begin
      language_q <= language_d;
    end
  end

  gdf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  gdf_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  gdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .language_i  (language_q),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  `GDF_ASSERT(a_last_is_digit, clk_i, rst_ni,
    !(out_valid_o && last_o) ||
    ((character_o >= gdf_pkg::CharZero) && (character_o <= gdf_pkg::CharNine)),
    "final character of a value is not a digit")

  `GDF_ASSERT(a_char_legal, clk_i, rst_ni,
    !out_valid_o ||
    ((character_o >= gdf_pkg::CharZero) && (character_o <= gdf_pkg::CharNine)) ||
    (character_o == gdf_pkg::SepEnglish) || (character_o == gdf_pkg::SepOther),
    "output character is neither digit nor separator")

  `GDF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
    in_valid_i && !in_stall_o, in_stall_o,
    "front end took no conversion cycle after an accepted item")

endmodule

// ===== test/tb_grouped_decimal_formatter.sv =====
`timescale 1ns / 100ps
// Testbench for grouped_decimal_formatter: random and directed values in, decimal text checked
// character by character against a predictor kept inside this file.
// Depends on gdf_pkg and the formatter RTL.
module tb_grouped_decimal_formatter;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseItems = 18;

  typedef struct packed {
    logic [gdf_pkg::CharW-1:0] ch;
    logic                      last;
  } text_char_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [gdf_pkg::ValueW-1:0]   value_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [gdf_pkg::CharW-1:0]    character_o;
  logic                         last_o;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [2:0]                   paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  logic [gdf_pkg::ValueW-1:0]   pending_values[$];
  text_char_t                   expected_chars[$];
  text_char_t                   want;
  logic [gdf_pkg::LangW-1:0]    lang_model = gdf_pkg::LangEnglish;
  logic                         in_fire = 1'b0;
  logic                         no_idle = 1'b0;
  logic                         hold_req = 1'b0;
  logic                         hold_done = 1'b0;
  int unsigned                  gap_left = 0;
  int unsigned                  hold_left = 0;
  int unsigned                  stall_left = 0;
  int unsigned                  run_left = 0;
  int unsigned                  cycle_count = 0;
  int unsigned                  error_count = 0;

  logic [31:0] lang_writes[6] = '{32'd0, 32'd4, 32'd7, 32'hFFFF_FFFA, 32'd5, 32'd3};

  grouped_decimal_formatter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .character_o(character_o),
    .last_o     (last_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [gdf_pkg::ValueW-1:0] random_value();
    int unsigned r;
    int unsigned digits;
    longint unsigned lo;
    longint unsigned hi;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 3) return $urandom();
    digits = $urandom_range(1, gdf_pkg::MaxDigits);
    lo = 1;
    repeat (digits - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return $urandom_range(hi[31:0], lo[31:0]);
  endfunction

  task automatic push_expected_text(input logic [gdf_pkg::ValueW-1:0] value);
    logic [gdf_pkg::DigitW-1:0] digs[gdf_pkg::MaxDigits];
    text_char_t                 chars[13];
    logic [gdf_pkg::ValueW-1:0] v;
    logic [gdf_pkg::ValueW-1:0] r10;
    logic [gdf_pkg::CharW-1:0]  sep;
    int                         n;
    int                         k;
    int                         i;
    sep = (lang_model == gdf_pkg::LangEnglish) ? gdf_pkg::SepEnglish : gdf_pkg::SepOther;
    v = value;
    n = 0;
    k = 0;
    if (v == 0) begin
      digs[0] = '0;
      n = 1;
    end
    while (v != 0) begin
      r10 = v % 10;
      digs[n] = r10[gdf_pkg::DigitW-1:0];
      v = v / 10;
      n++;
    end
    for (i = n - 1; i >= 0; i--) begin
      chars[k] = '{ch: gdf_pkg::CharZero +
                       {{gdf_pkg::CharW-gdf_pkg::DigitW{1'b0}}, digs[i]},
                   last: 1'b0};
      k++;
      if (i > 0 && (i % 3) == 0) begin
        chars[k] = '{ch: sep, last: 1'b0};
        k++;
      end
    end
    chars[k-1].last = 1'b1;
    for (i = 0; i < k; i++) expected_chars.push_back(chars[i]);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((addr >> 2) == gdf_pkg::RegLanguage) lang_model = data[gdf_pkg::LangW-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_values.size() != 0 || in_valid_i || expected_chars.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // sender: hold the item until taken, then idle a random gap
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!(in_valid_i && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_values.size() != 0) begin
        in_valid_i <= 1'b1;
        value_i    <= pending_values.pop_front();
        gap_left = gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall_i <= 1'b0;
    end else begin
      stall_left = gap_len();
      run_left = no_idle ? 0 : $urandom_range(0, 6);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) push_expected_text(value_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          error_count++;
          $display("%0t: unexpected item character %h last %b", $time, character_o, last_o);
        end else begin
          want = expected_chars.pop_front();
          if (character_o !== want.ch) begin
            error_count++;
            $display("%0t: character expected %h actual %h", $time, want.ch, character_o);
          end
          if (last_o !== want.last) begin
            error_count++;
            $display("%0t: last expected %b actual %b", $time, want.last, last_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // digit counts at each grouping boundary, bit patterns, extremes
    pending_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
                       32'd9999, 32'd12345, 32'd999999, 32'd1000000, 32'd999999999,
                       32'd1000000000, 32'd1234567890, 32'h8000_0000, 32'hAAAA_AAAA,
                       32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    wait_drained();
    apb_write(3'd0, 32'd1);
    pending_values = '{32'd0, 32'd1000, 32'hFFFF_FFFF};
    wait_drained();
    // address past the register list: language must stay as it is
    apb_write(3'd4, 32'd0);
    pending_values = '{32'd1000, 32'd4294967};
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      apb_write(3'd0, lang_writes[p]);
      no_idle = (p == 4);
      repeat (PhaseItems) pending_values.push_back(random_value());
      if (p == 2) hold_req = 1'b1;
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (30) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
